// ----- rtl/cau_pkg.sv -----
// shared types and command codes for the complex arithmetic unit
// no dependencies
package cau_pkg;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_ADD = 2'd0;
    localparam t_cmd CMD_SUB = 2'd1;
    localparam t_cmd CMD_MUL = 2'd2;
    localparam t_cmd CMD_DIV = 2'd3;

endpackage

// ----- rtl/cau_front.sv -----
// front pipeline: operand register, partial products, sums and divisor
// depends on cau_pkg
module cau_front #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  cau_pkg::t_cmd         i_command,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    input  logic signed [W-1:0]   i_c,
    input  logic signed [W-1:0]   i_d,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cau_pkg::t_cmd         o_command,
    output logic signed [W:0]     o_as_re,
    output logic signed [W:0]     o_as_im,
    output logic signed [2*W:0]   o_mul_re,
    output logic signed [2*W:0]   o_mul_im,
    output logic signed [2*W:0]   o_num_re,
    output logic signed [2*W:0]   o_num_im,
    output logic [2*W-1:0]        o_den
);
    import cau_pkg::*;

    localparam int P = 2 * W;
    localparam int S = 2 * W + 1;

    logic                r_v1, r_v2, r_v3;
    logic                rdy1, rdy2, rdy3;
    t_cmd                r_cmd1, r_cmd2, r_cmd3;
    logic signed [W-1:0] r_a, r_b, r_c, r_d;
    logic signed [W:0]   r_as_re2, r_as_im2, r_as_re3, r_as_im3;
    logic signed [W:0]   n_as_re, n_as_im;
    logic signed [P-1:0] r_pac, r_pbd, r_pbc, r_pad, r_pcc, r_pdd;
    logic signed [P-1:0] n_pac, n_pbd, n_pbc, n_pad, n_pcc, n_pdd;
    logic signed [S-1:0] r_mre, r_mim, r_nre, r_nim;
    logic [P-1:0]        r_den;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        if (r_cmd1 == CMD_SUB) begin
            n_as_re = (W+1)'(r_a) - (W+1)'(r_c);
            n_as_im = (W+1)'(r_b) - (W+1)'(r_d);
        end else begin
            n_as_re = (W+1)'(r_a) + (W+1)'(r_c);
            n_as_im = (W+1)'(r_b) + (W+1)'(r_d);
        end
        n_pac = r_a * r_c;
        n_pbd = r_b * r_d;
        n_pbc = r_b * r_c;
        n_pad = r_a * r_d;
        n_pcc = r_c * r_c;
        n_pdd = r_d * r_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_cmd1 <= i_command;
            r_a    <= i_a;
            r_b    <= i_b;
            r_c    <= i_c;
            r_d    <= i_d;
        end
        if (rdy2 && r_v1) begin
            r_cmd2   <= r_cmd1;
            r_as_re2 <= n_as_re;
            r_as_im2 <= n_as_im;
            r_pac    <= n_pac;
            r_pbd    <= n_pbd;
            r_pbc    <= n_pbc;
            r_pad    <= n_pad;
            r_pcc    <= n_pcc;
            r_pdd    <= n_pdd;
        end
        if (rdy3 && r_v2) begin
            r_cmd3   <= r_cmd2;
            r_as_re3 <= r_as_re2;
            r_as_im3 <= r_as_im2;
            r_mre    <= S'(r_pac) - S'(r_pbd);
            r_mim    <= S'(r_pbc) + S'(r_pad);
            r_nre    <= S'(r_pac) + S'(r_pbd);
            r_nim    <= S'(r_pbc) - S'(r_pad);
            r_den    <= $unsigned(r_pcc) + $unsigned(r_pdd);
        end
    end

    assign o_valid   = r_v3;
    assign o_command = r_cmd3;
    assign o_as_re   = r_as_re3;
    assign o_as_im   = r_as_im3;
    assign o_mul_re  = r_mre;
    assign o_mul_im  = r_mim;
    assign o_num_re  = r_nre;
    assign o_num_im  = r_nim;
    assign o_den     = r_den;

endmodule

// ----- rtl/cau_div_cell.sv -----
// one restoring division cell: one quotient bit per lane, two lanes
// no package dependencies
module cau_div_cell #(
    parameter int W  = 32,
    parameter int SW = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2*W-1:0]         i_den,
    input  logic [1:0][2*W-1:0]    i_rem,
    input  logic [1:0][W-1:0]      i_nbits,
    input  logic [1:0][W-1:0]      i_quo,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2*W-1:0]         o_den,
    output logic [1:0][2*W-1:0]    o_rem,
    output logic [1:0][W-1:0]      o_nbits,
    output logic [1:0][W-1:0]      o_quo,
    output logic [SW-1:0]          o_side
);

    logic                r_valid;
    logic [2*W-1:0]      r_den;
    logic [1:0][2*W-1:0] r_rem, n_rem;
    logic [1:0][W-1:0]   r_nbits, n_nbits, r_quo, n_quo;
    logic [SW-1:0]       r_side;
    logic [1:0][2*W:0]   trial, diff;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            trial[l]   = {i_rem[l], i_nbits[l][W-1]};
            diff[l]    = trial[l] - {1'b0, i_den};
            n_rem[l]   = diff[l][2*W] ? trial[l][2*W-1:0] : diff[l][2*W-1:0];
            n_quo[l]   = {i_quo[l][W-2:0], !diff[l][2*W]};
            n_nbits[l] = {i_nbits[l][W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_den   <= i_den;
            r_rem   <= n_rem;
            r_nbits <= n_nbits;
            r_quo   <= n_quo;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_nbits = r_nbits;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

// ----- rtl/complex_arith_unit.sv -----
// top level: front pipeline, divider setup, chain of division cells, output stage
// depends on cau_pkg, cau_front, cau_div_cell
//
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_command, i_lhs_*, i_rhs_*
// result    out        o_valid / i_stall    o_res_real, o_res_imag, o_overflow, o_div_zero
//
// one transaction per cycle sustained while i_stall is low, every command takes the same path
// the path is three front stages, divider setup,
// one cell per quotient bit, output register
// every stage holds its own valid, so bubbles collapse under a result stall
// reset clears all valid bits, payload registers are not reset
module complex_arith_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  cau_pkg::t_cmd                i_command,
    input  logic signed [DATA_WIDTH-1:0] i_lhs_real,
    input  logic signed [DATA_WIDTH-1:0] i_lhs_imag,
    input  logic signed [DATA_WIDTH-1:0] i_rhs_real,
    input  logic signed [DATA_WIDTH-1:0] i_rhs_imag,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_res_real,
    output logic signed [DATA_WIDTH-1:0] o_res_imag,
    output logic                         o_overflow,
    output logic                         o_div_zero
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int P  = 2 * W;
    localparam int S  = 2 * W + 1;
    localparam int NW = P + F;
    localparam int SW = 2 * W + 7;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    logic                f_valid, f_ready;
    logic                r4_ready;
    t_cmd                f_cmd;
    logic signed [W:0]   f_as_re, f_as_im;
    logic signed [S-1:0] f_mre, f_mim, f_nre, f_nim;
    logic [P-1:0]        f_den;

    cau_front #(.W(W)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (f_ready),
        .i_command (i_command),
        .i_a       (i_lhs_real),
        .i_b       (i_lhs_imag),
        .i_c       (i_rhs_real),
        .i_d       (i_rhs_imag),
        .o_valid   (f_valid),
        .i_ready   (r4_ready),
        .o_command (f_cmd),
        .o_as_re   (f_as_re),
        .o_as_im   (f_as_im),
        .o_mul_re  (f_mre),
        .o_mul_im  (f_mim),
        .o_num_re  (f_nre),
        .o_num_im  (f_nim),
        .o_den     (f_den)
    );

    assign o_stall = !f_ready;

    // divider setup and add, subtract, multiply results
    logic                r_v4;
    logic [P-1:0]        r_den4;
    logic [1:0][P-1:0]   r_rem4, n_rem4;
    logic [1:0][W-1:0]   r_nb4, n_nb4;
    logic [SW-1:0]       r_side4, n_side4;
    logic [1:0][S-1:0]   fv;
    logic [1:0][W-1:0]   fres;
    logic [1:0]          fovf, nneg, qovf;
    logic [1:0][S-1:0]   nabs;
    logic [1:0][NW-1:0]  nsh, r0;
    logic signed [S-1:0] msh_re, msh_im;

    always_comb begin
        msh_re = f_mre >>> F;
        msh_im = f_mim >>> F;
        if (f_cmd == CMD_MUL) begin
            fv[0] = msh_re;
            fv[1] = msh_im;
        end else begin
            fv[0] = {{(S-W-1){f_as_re[W]}}, f_as_re};
            fv[1] = {{(S-W-1){f_as_im[W]}}, f_as_im};
        end
        nabs[0] = f_nre[S-1] ? (~f_nre + 1'b1) : f_nre;
        nabs[1] = f_nim[S-1] ? (~f_nim + 1'b1) : f_nim;
        nneg[0] = f_nre[S-1];
        nneg[1] = f_nim[S-1];
        for (int l = 0; l < 2; l++) begin
            if ((&fv[l][S-1:W-1]) || !(|fv[l][S-1:W-1])) begin
                fres[l] = fv[l][W-1:0];
                fovf[l] = 1'b0;
            end else begin
                fres[l] = fv[l][S-1] ? VMIN : VMAX;
                fovf[l] = 1'b1;
            end
            nsh[l]    = NW'(nabs[l][P-1:0]) << F;
            r0[l]     = nsh[l] >> W;
            qovf[l]   = r0[l] >= NW'(f_den);
            n_rem4[l] = r0[l][P-1:0];
            n_nb4[l]  = nsh[l][W-1:0];
        end
        n_side4 = {f_cmd == CMD_DIV, f_den == '0, fres[0], fres[1], |fovf,
                   nneg[0], nneg[1], qovf[0], qovf[1]};
    end

    logic [W:0]               c_valid, c_ready;
    logic [W:0][P-1:0]        c_den;
    logic [W:0][1:0][P-1:0]   c_rem;
    logic [W:0][1:0][W-1:0]   c_nb, c_quo;
    logic [W:0][SW-1:0]       c_side;

    assign r4_ready = !r_v4 || c_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (r4_ready) begin
            r_v4 <= f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r4_ready && f_valid) begin
            r_den4  <= f_den;
            r_rem4  <= n_rem4;
            r_nb4   <= n_nb4;
            r_side4 <= n_side4;
        end
    end

    assign c_valid[0] = r_v4;
    assign c_den[0]   = r_den4;
    assign c_rem[0]   = r_rem4;
    assign c_nb[0]    = r_nb4;
    assign c_quo[0]   = '0;
    assign c_side[0]  = r_side4;

    for (genvar k = 0; k < W; k++) begin : g_cell
        cau_div_cell #(.W(W), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_den   (c_den[k]),
            .i_rem   (c_rem[k]),
            .i_nbits (c_nb[k]),
            .i_quo   (c_quo[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_den   (c_den[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_nbits (c_nb[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    // output register
    logic              r_ov;
    logic [W-1:0]      r_re, r_im, n_re, n_im;
    logic              r_ovf, r_dz, n_ovf, n_dz;
    logic [SW-1:0]     sd;
    logic [1:0][W-1:0] q, dres;
    logic [1:0]        dovf, sneg, sqo;

    assign c_ready[W] = !r_ov || !i_stall;
    assign sd         = c_side[W];
    assign q          = c_quo[W];

    always_comb begin
        sneg = {sd[2], sd[3]};
        sqo  = {sd[0], sd[1]};
        for (int l = 0; l < 2; l++) begin
            dovf[l] = sqo[l] || (sneg[l] ? (q[l][W-1] && (|q[l][W-2:0])) : q[l][W-1]);
            if (dovf[l]) begin
                dres[l] = sneg[l] ? VMIN : VMAX;
            end else begin
                dres[l] = sneg[l] ? (~q[l] + 1'b1) : q[l];
            end
        end
        if (!sd[SW-1]) begin
            n_re  = sd[SW-3 -: W];
            n_im  = sd[SW-3-W -: W];
            n_ovf = sd[4];
            n_dz  = 1'b0;
        end else if (sd[SW-2]) begin
            n_re  = '0;
            n_im  = '0;
            n_ovf = 1'b0;
            n_dz  = 1'b1;
        end else begin
            n_re  = dres[0];
            n_im  = dres[1];
            n_ovf = |dovf;
            n_dz  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (c_ready[W]) begin
            r_ov <= c_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready[W] && c_valid[W]) begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_ovf <= n_ovf;
            r_dz  <= n_dz;
        end
    end

    assign o_valid    = r_ov;
    assign o_res_real = r_re;
    assign o_res_imag = r_im;
    assign o_overflow = r_ovf;
    assign o_div_zero = r_dz;

endmodule

// ----- bench/tb_complex_arith_unit.sv -----
// self-checking bench for complex_arith_unit: add, subtract, multiply, divide in Q16.16
// depends on cau_pkg and the complex_arith_unit rtl
module tb_complex_arith_unit;
    import cau_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int LATENCY = DW + 5;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1930;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 ovf;
        logic                 dz;
    } t_cplx_result;

    class cplx_scoreboard;
        t_cplx_result pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // saturate a wide signed value into a result part
        static function logic signed [DW-1:0] clamp(input logic signed [199:0] v,
                                                     inout logic ovf);
            logic signed [199:0] hi;
            logic signed [199:0] lo;
            hi = (200'sd1 <<< (DW-1)) - 1;
            lo = -(200'sd1 <<< (DW-1));
            if (v > hi) begin
                ovf = 1'b1;
                return hi[DW-1:0];
            end
            if (v < lo) begin
                ovf = 1'b1;
                return lo[DW-1:0];
            end
            return v[DW-1:0];
        endfunction

        // quotient scaled by 2^FB, truncated toward zero
        static function logic signed [199:0] scaled_quot(input logic signed [199:0] num,
                                                        input logic signed [199:0] den);
            logic [199:0] mag;
            logic neg;
            neg = num < 0;
            mag = neg ? -num : num;
            mag = (mag << FB) / den;
            return neg ? -$signed(mag) : $signed(mag);
        endfunction

        function void note_operands(t_cmd cmd, logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                                    logic signed [DW-1:0] c, logic signed [DW-1:0] d);
            logic signed [199:0] wa, wb, wc, wd, re, im, den;
            t_cplx_result r;
            wa = a; wb = b; wc = c; wd = d;
            r = '0;
            re = 0;
            im = 0;
            case (cmd)
                CMD_ADD: begin
                    re = wa + wc;
                    im = wb + wd;
                end
                CMD_SUB: begin
                    re = wa - wc;
                    im = wb - wd;
                end
                CMD_MUL: begin
                    re = (wa * wc - wb * wd) >>> FB;
                    im = (wb * wc + wa * wd) >>> FB;
                end
                default: begin
                    den = wc * wc + wd * wd;
                    if (den == 0) begin
                        r.dz = 1'b1;
                    end else begin
                        re = scaled_quot(wa * wc + wb * wd, den);
                        im = scaled_quot(wb * wc - wa * wd, den);
                    end
                end
            endcase
            r.re = clamp(re, r.ovf);
            r.im = clamp(im, r.ovf);
            pending.push_back(r);
        endfunction

        function void check_result(t_cplx_result got);
            t_cplx_result exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result transaction re=%h im=%h", got.re, got.im);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.re !== exp_r.re) begin
                $error("res_real expected %h actual %h", exp_r.re, got.re);
                errors++;
            end
            if (got.im !== exp_r.im) begin
                $error("res_imag expected %h actual %h", exp_r.im, got.im);
                errors++;
            end
            if (got.ovf !== exp_r.ovf) begin
                $error("overflow expected %b actual %b", exp_r.ovf, got.ovf);
                errors++;
            end
            if (got.dz !== exp_r.dz) begin
                $error("div_zero expected %b actual %b", exp_r.dz, got.dz);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_cmd i_command = CMD_ADD;
    logic signed [DW-1:0] i_lhs_real = '0;
    logic signed [DW-1:0] i_lhs_imag = '0;
    logic signed [DW-1:0] i_rhs_real = '0;
    logic signed [DW-1:0] i_rhs_imag = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [DW-1:0] o_res_real;
    logic signed [DW-1:0] o_res_imag;
    logic o_overflow;
    logic o_div_zero;

    cplx_scoreboard sb = new();
    bit hold_off_req = 0;
    int idle_cycles = 0;

    complex_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(7))
            0: return $signed($urandom());
            1: return $signed(32'h8000_0000 + $urandom_range(3));
            2: return $signed(32'h7fff_ffff - $urandom_range(3));
            3: return $signed($urandom_range(8)) - 4;
            4: return $signed($urandom_range(32'h0004_0000)) - $signed(32'h0002_0000);
            5: return $signed($urandom_range(32'h0100_0000)) - $signed(32'h0080_0000);
            default: return $signed($urandom()) >>> $urandom_range(31);
        endcase
    endfunction

    task automatic send_operands(t_cmd cmd, logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                                 logic signed [DW-1:0] c, logic signed [DW-1:0] d);
        i_command <= cmd;
        i_lhs_real <= a;
        i_lhs_imag <= b;
        i_rhs_real <= c;
        i_rhs_imag <= d;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_operands(cmd, a, b, c, d);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // receiver side stall pattern, with one long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (3 * LATENCY) @(negedge i_clk);
                hold_off_req = 0;
                i_stall <= 1'b0;
            end else begin
                n = gap_len();
                if (n == 0 || $urandom_range(3) == 0) begin
                    i_stall <= 1'b0;
                end else begin
                    i_stall <= 1'b1;
                    repeat (n - 1) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_res_real, o_res_imag, o_overflow, o_div_zero});
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic signed [DW-1:0] mx, mn, one;
        t_cmd cmd;
        int gap;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        one = 32'h0001_0000;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, each command, zero divisor
        send_operands(CMD_ADD, mx, mn, one, mn);
        send_operands(CMD_ADD, mn, mx, -one, mx);
        send_operands(CMD_SUB, mn, mx, one, -one);
        send_operands(CMD_SUB, 0, 0, mn, mn);
        send_operands(CMD_MUL, one, one, one, one);
        send_operands(CMD_MUL, mn, mn, mn, mn);
        send_operands(CMD_MUL, mx, mn, mx, mx);
        send_operands(CMD_MUL, -1, 1, 1, 1);
        send_operands(CMD_MUL, -1, 0, 3, 0);
        send_operands(CMD_DIV, one, 0, 0, 0);
        send_operands(CMD_DIV, mn, mx, 0, 0);
        send_operands(CMD_DIV, one, one, one, one);
        send_operands(CMD_DIV, mx, mn, 1, 0);
        send_operands(CMD_DIV, mn, mn, mn, mn);
        send_operands(CMD_DIV, -one, one, 3 * one, 0);
        send_operands(CMD_DIV, 1, 0, 0, mx);
        send_operands(CMD_DIV, mx, mx, mx, mx);
        send_operands(CMD_DIV, 5, -7, 0, -1);
        // sender waits for every expected result
        drain();
        // receiver holds off while the sender keeps offering
        hold_off_req = 1;
        for (int i = 0; i < N_RANDOM; i++) begin
            cmd = t_cmd'($urandom_range(3));
            if (i == N_RANDOM / 2) drain();
            if (cmd == CMD_DIV && $urandom_range(15) == 0)
                send_operands(cmd, pick_value(), pick_value(), 0, 0);
            else
                send_operands(cmd, pick_value(), pick_value(), pick_value(), pick_value());
            if (i > 200 && (i % 300) < 60) continue;
            gap = gap_len();
            if (gap != 0) pause_sender(gap);
        end
        drain();
        repeat (LATENCY + 10) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
